FILE: rtl/prim_minimum_spanning_tree_top_defines.svh
// Assertion macros used by the spanning tree datapath.
`ifndef PRIM_MINIMUM_SPANNING_TREE_TOP_DEFINES_SVH
`define PRIM_MINIMUM_SPANNING_TREE_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge.
`define PMST_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmst: same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge.
`define PMST_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmst: next-cycle check failed");

`endif

FILE: rtl/pmst_pkg.sv
`timescale 1ns / 1ps
package pmst_pkg;

   // Sizes
   localparam int MAX_VERTICES = 16;
   localparam int VTX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = VTX_W + 1;
   localparam int ADDR_W       = 2 * VTX_W;
   localparam int ADJ_DEPTH    = MAX_VERTICES * MAX_VERTICES;
   localparam int COST_W       = 8;
   localparam int PC_W         = 5;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 8;

   // Reset values of the configuration registers
   localparam logic [CNT_W-1:0]  RESET_VERTEX_COUNT = CNT_W'(16);
   localparam logic [COST_W-1:0] RESET_NO_EDGE      = COST_W'(100);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_EDGE_COST = 1'b1;

   // Request modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_VERTEX  = 2'd1;
   localparam logic [1:0] ST_WEIGHT  = 2'd2;
   localparam logic [1:0] ST_UNREACH = 2'd3;

   typedef struct packed {
      logic [1:0]        mode;
      logic [VTX_W-1:0]  vertex_a;
      logic [VTX_W-1:0]  vertex_b;
      logic [COST_W-1:0] edge_cost;
   } pmst_req_type;

   typedef struct packed {
      logic [VTX_W-1:0]  from_vertex;
      logic [VTX_W-1:0]  to_vertex;
      logic [COST_W-1:0] cost;
      logic [1:0]        status;
      logic              last;
   } pmst_rsp_type;

   // Datapath actions, one per control word
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_FILL_RESET,
      ACT_FILL_CFG,
      ACT_CLEAR_STEP,
      ACT_WRITE_AB,
      ACT_WRITE_BA,
      ACT_EMIT_ERR,
      ACT_RUN_INIT,
      ACT_INIT_STEP,
      ACT_SEARCH_INIT,
      ACT_SEARCH_STEP,
      ACT_EMIT_EDGE,
      ACT_UPDATE_STEP
   } pmst_act_type;

   // Jump conditions
   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_MODE_CLEAR,
      COND_MODE_RUN,
      COND_MODE_NOT_WRITE,
      COND_WRITE_BAD,
      COND_START_BAD,
      COND_N_ONE,
      COND_J_NOT_N,
      COND_J_NOT_LAST,
      COND_LAST_ROUND,
      COND_CLR_NOT_DONE
   } pmst_cond_type;

   typedef struct packed {
      pmst_act_type    act;
      pmst_cond_type   cond;
      logic [PC_W-1:0] target;
   } pmst_ucode_type;

   // Sequencer to datapath
   typedef struct packed {
      pmst_act_type act;
      logic         accept;
   } pmst_cmd_type;

   // Datapath to sequencer
   typedef struct packed {
      logic mode_clear;
      logic mode_run;
      logic mode_write;
      logic write_bad;
      logic start_bad;
      logic n_one;
      logic j_not_n;
      logic j_not_last;
      logic last_round;
      logic clr_not_done;
   } pmst_flags_type;

endpackage

FILE: rtl/pmst_seq.sv
`timescale 1ns / 1ps
module pmst_seq
   import pmst_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  pmst_flags_type flags,
   output pmst_cmd_type   cmd,
   output logic           busy
);

   // Program addresses
   localparam logic [PC_W-1:0] STEP_RST       = PC_W'(0);
   localparam logic [PC_W-1:0] STEP_CLEAR     = PC_W'(1);
   localparam logic [PC_W-1:0] STEP_IDLE      = PC_W'(2);
   localparam logic [PC_W-1:0] STEP_DISPATCH  = PC_W'(3);
   localparam logic [PC_W-1:0] STEP_IS_RUN    = PC_W'(4);
   localparam logic [PC_W-1:0] STEP_IS_WRITE  = PC_W'(5);
   localparam logic [PC_W-1:0] STEP_WR_CHECK  = PC_W'(6);
   localparam logic [PC_W-1:0] STEP_WR_AB     = PC_W'(7);
   localparam logic [PC_W-1:0] STEP_WR_BA     = PC_W'(8);
   localparam logic [PC_W-1:0] STEP_ERROR     = PC_W'(9);
   localparam logic [PC_W-1:0] STEP_RUN       = PC_W'(10);
   localparam logic [PC_W-1:0] STEP_RUN_INIT  = PC_W'(11);
   localparam logic [PC_W-1:0] STEP_LOAD_ROW  = PC_W'(12);
   localparam logic [PC_W-1:0] STEP_ROUND     = PC_W'(13);
   localparam logic [PC_W-1:0] STEP_SEARCH    = PC_W'(14);
   localparam logic [PC_W-1:0] STEP_EMIT      = PC_W'(15);
   localparam logic [PC_W-1:0] STEP_UPDATE    = PC_W'(16);
   localparam logic [PC_W-1:0] STEP_LOOP      = PC_W'(17);
   localparam logic [PC_W-1:0] STEP_CLR_PREP  = PC_W'(18);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   pmst_ucode_type  word;
   logic            take;

   // Control store
   function automatic pmst_ucode_type rom_word(input logic [PC_W-1:0] pc);
      pmst_ucode_type w;
      unique case (pc)
         STEP_RST:      w = '{ACT_FILL_RESET,  COND_NEVER,          STEP_RST};
         STEP_CLEAR:    w = '{ACT_CLEAR_STEP,  COND_CLR_NOT_DONE,   STEP_CLEAR};
         STEP_IDLE:     w = '{ACT_NONE,        COND_NO_START,       STEP_IDLE};
         STEP_DISPATCH: w = '{ACT_NONE,        COND_MODE_CLEAR,     STEP_CLR_PREP};
         STEP_IS_RUN:   w = '{ACT_NONE,        COND_MODE_RUN,       STEP_RUN};
         STEP_IS_WRITE: w = '{ACT_NONE,        COND_MODE_NOT_WRITE, STEP_IDLE};
         STEP_WR_CHECK: w = '{ACT_NONE,        COND_WRITE_BAD,      STEP_ERROR};
         STEP_WR_AB:    w = '{ACT_WRITE_AB,    COND_NEVER,          STEP_IDLE};
         STEP_WR_BA:    w = '{ACT_WRITE_BA,    COND_ALWAYS,         STEP_IDLE};
         STEP_ERROR:    w = '{ACT_EMIT_ERR,    COND_ALWAYS,         STEP_IDLE};
         STEP_RUN:      w = '{ACT_NONE,        COND_START_BAD,      STEP_ERROR};
         STEP_RUN_INIT: w = '{ACT_RUN_INIT,    COND_N_ONE,          STEP_IDLE};
         STEP_LOAD_ROW: w = '{ACT_INIT_STEP,   COND_J_NOT_N,        STEP_LOAD_ROW};
         STEP_ROUND:    w = '{ACT_SEARCH_INIT, COND_NEVER,          STEP_IDLE};
         STEP_SEARCH:   w = '{ACT_SEARCH_STEP, COND_J_NOT_LAST,     STEP_SEARCH};
         STEP_EMIT:     w = '{ACT_EMIT_EDGE,   COND_LAST_ROUND,     STEP_IDLE};
         STEP_UPDATE:   w = '{ACT_UPDATE_STEP, COND_J_NOT_N,        STEP_UPDATE};
         STEP_LOOP:     w = '{ACT_NONE,        COND_ALWAYS,         STEP_ROUND};
         STEP_CLR_PREP: w = '{ACT_FILL_CFG,    COND_ALWAYS,         STEP_CLEAR};
         default:       w = '{ACT_NONE,        COND_ALWAYS,         STEP_IDLE};
      endcase
      return w;
   endfunction

   // Evaluate the jump condition and pick the next step
   always_comb begin
      word = rom_word(pc_ff);
      unique case (word.cond)
         COND_NEVER:          take = 1'b0;
         COND_ALWAYS:         take = 1'b1;
         COND_NO_START:       take = !start;
         COND_MODE_CLEAR:     take = flags.mode_clear;
         COND_MODE_RUN:       take = flags.mode_run;
         COND_MODE_NOT_WRITE: take = !flags.mode_write;
         COND_WRITE_BAD:      take = flags.write_bad;
         COND_START_BAD:      take = flags.start_bad;
         COND_N_ONE:          take = flags.n_one;
         COND_J_NOT_N:        take = flags.j_not_n;
         COND_J_NOT_LAST:     take = flags.j_not_last;
         COND_LAST_ROUND:     take = flags.last_round;
         COND_CLR_NOT_DONE:   take = flags.clr_not_done;
         default:             take = 1'b0;
      endcase
      pc_in = take ? word.target : pc_ff + PC_W'(1);
      busy  = (pc_ff != STEP_IDLE);
      cmd.act    = word.act;
      cmd.accept = (pc_ff == STEP_IDLE) && start;
   end

   // Step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_RST;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

FILE: rtl/pmst_datapath.sv
`timescale 1ns / 1ps
`include "prim_minimum_spanning_tree_top_defines.svh"
module pmst_datapath
   import pmst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  pmst_cmd_type          cmd,
   input  pmst_req_type          req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output pmst_flags_type        flags,
   output logic                  rsp_valid,
   output pmst_rsp_type          rsp_data
);

   // Configuration
   logic [CNT_W-1:0]  vertex_count_ff;
   logic [COST_W-1:0] no_edge_ff;

   // Working registers
   pmst_req_type         req_ff;
   logic [COST_W-1:0]    fill_ff, fill_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [VTX_W-1:0]     k_ff, k_in;
   logic [COST_W-1:0]    best_ff, best_in;
   logic                 found_ff, found_in;
   logic [MAX_VERTICES-1:0] in_tree_ff, in_tree_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pmst_rsp_type         rsp_ff, rsp_in;

   // Adjacency memory
   logic [COST_W-1:0] adj_mem [ADJ_DEPTH];
   logic [COST_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [COST_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   // Per-vertex best link
   logic [COST_W-1:0] cc_arr  [MAX_VERTICES];
   logic [VTX_W-1:0]  ctv_arr [MAX_VERTICES];
   logic [VTX_W-1:0]  arr_idx;
   logic [COST_W-1:0] cc_rd;
   logic [VTX_W-1:0]  ctv_rd;
   logic              arr_we;
   logic [COST_W-1:0] cc_wdata;
   logic [VTX_W-1:0]  ctv_wdata;

   logic [CNT_W-1:0]  n;
   logic [CNT_W-1:0]  a_ext;
   logic [CNT_W-1:0]  b_ext;
   logic [VTX_W-1:0]  jd;
   logic              vtx_bad;

   // Clamp the vertex count to the supported range
   always_comb begin
      if (vertex_count_ff > CNT_W'(MAX_VERTICES)) begin
         n = CNT_W'(MAX_VERTICES);
      end else if (vertex_count_ff == '0) begin
         n = CNT_W'(1);
      end else begin
         n = vertex_count_ff;
      end
   end

   assign a_ext   = CNT_W'(req_ff.vertex_a);
   assign b_ext   = CNT_W'(req_ff.vertex_b);
   assign jd      = VTX_W'(j_ff - CNT_W'(1));
   assign vtx_bad = (a_ext >= n) || (b_ext >= n);

   // Status for the sequencer
   always_comb begin
      flags.mode_clear   = (req_ff.mode == MODE_CLEAR);
      flags.mode_run     = (req_ff.mode == MODE_RUN);
      flags.mode_write   = (req_ff.mode == MODE_WRITE);
      flags.write_bad    = vtx_bad || (req_ff.edge_cost == '0)
                           || (req_ff.edge_cost >= no_edge_ff);
      flags.start_bad    = (a_ext >= n);
      flags.n_one        = (n == CNT_W'(1));
      flags.j_not_n      = (j_ff != n);
      flags.j_not_last   = (j_ff != n - CNT_W'(1));
      flags.last_round   = (i_ff == n - CNT_W'(1));
      flags.clr_not_done = (clr_addr_ff != '1);
   end

   // Read the best-link arrays at one index per cycle
   always_comb begin
      unique case (cmd.act)
         ACT_EMIT_EDGE:   arr_idx = k_ff;
         ACT_SEARCH_STEP: arr_idx = j_ff[VTX_W-1:0];
         default:         arr_idx = jd;
      endcase
      cc_rd  = cc_arr[arr_idx];
      ctv_rd = ctv_arr[arr_idx];
   end

   // Datapath actions
   always_comb begin
      fill_in      = fill_ff;
      clr_addr_in  = clr_addr_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      in_tree_in   = in_tree_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_addr_ff;
      mem_wdata    = fill_ff;
      mem_raddr    = {k_ff, j_ff[VTX_W-1:0]};
      arr_we       = 1'b0;
      cc_wdata     = rd_data_ff;
      ctv_wdata    = req_ff.vertex_a;

      unique case (cmd.act)
         ACT_NONE: begin
         end
         ACT_FILL_RESET: begin
            fill_in     = RESET_NO_EDGE;
            clr_addr_in = '0;
         end
         ACT_FILL_CFG: begin
            fill_in     = no_edge_ff;
            clr_addr_in = '0;
         end
         ACT_CLEAR_STEP: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
         ACT_WRITE_AB: begin
            mem_we    = 1'b1;
            mem_waddr = {req_ff.vertex_a, req_ff.vertex_b};
            mem_wdata = req_ff.edge_cost;
         end
         ACT_WRITE_BA: begin
            mem_we    = 1'b1;
            mem_waddr = {req_ff.vertex_b, req_ff.vertex_a};
            mem_wdata = req_ff.edge_cost;
         end
         ACT_EMIT_ERR: begin
            rsp_valid_in       = 1'b1;
            rsp_in.from_vertex = req_ff.vertex_a;
            rsp_in.to_vertex   = flags.mode_run ? req_ff.vertex_a : req_ff.vertex_b;
            rsp_in.cost        = '0;
            rsp_in.status      = (flags.mode_run || vtx_bad) ? ST_VERTEX : ST_WEIGHT;
            rsp_in.last        = 1'b1;
         end
         ACT_RUN_INIT: begin
            j_in       = '0;
            i_in       = CNT_W'(1);
            in_tree_in = '0;
            in_tree_in[req_ff.vertex_a] = 1'b1;
         end
         ACT_INIT_STEP: begin
            // Read the start row, store the previous column's cost
            mem_raddr = {req_ff.vertex_a, j_ff[VTX_W-1:0]};
            arr_we    = (j_ff != '0);
            j_in      = j_ff + CNT_W'(1);
         end
         ACT_SEARCH_INIT: begin
            j_in     = '0;
            found_in = 1'b0;
         end
         ACT_SEARCH_STEP: begin
            // Keep the first strictly cheaper vertex outside the tree
            if (!in_tree_ff[j_ff[VTX_W-1:0]] && (!found_ff || cc_rd < best_ff)) begin
               found_in = 1'b1;
               best_in  = cc_rd;
               k_in     = j_ff[VTX_W-1:0];
            end
            j_in = j_ff + CNT_W'(1);
         end
         ACT_EMIT_EDGE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.from_vertex = ctv_rd;
            rsp_in.to_vertex   = k_ff;
            rsp_in.cost        = best_ff;
            rsp_in.status      = (best_ff >= no_edge_ff) ? ST_UNREACH : ST_OK;
            rsp_in.last        = flags.last_round;
            in_tree_in[k_ff]   = 1'b1;
            i_in               = i_ff + CNT_W'(1);
            j_in               = '0;
         end
         ACT_UPDATE_STEP: begin
            // Read row k, relax the previous column on a strictly cheaper edge
            arr_we    = (j_ff != '0) && !in_tree_ff[jd] && (rd_data_ff < cc_rd);
            ctv_wdata = k_ff;
            j_in      = j_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= RESET_VERTEX_COUNT;
         no_edge_ff      <= RESET_NO_EDGE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_NO_EDGE_COST: no_edge_ff      <= csr_wdata[COST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         in_tree_ff   <= '0;
         found_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         in_tree_ff   <= in_tree_in;
         found_ff     <= found_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      fill_ff     <= fill_in;
      clr_addr_ff <= clr_addr_in;
      j_ff        <= j_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      best_ff     <= best_in;
      rsp_ff      <= rsp_in;
   end

   // Adjacency memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         adj_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= adj_mem[mem_raddr];
   end

   // Best-link arrays, written at the previous column
   always_ff @(posedge clock) begin
      if (arr_we) begin
         cc_arr[jd]  <= cc_wdata;
         ctv_arr[jd] <= ctv_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PMST_ASSERT_IMP(a_emit_has_candidate, clock, reset,
                    cmd.act == ACT_EMIT_EDGE, found_ff && !in_tree_ff[k_ff])
   `PMST_ASSERT_NXT(a_emit_joins_tree, clock, reset,
                    cmd.act == ACT_EMIT_EDGE, rsp_valid_ff && in_tree_ff[rsp_ff.to_vertex])
   `PMST_ASSERT_IMP(a_ok_below_no_edge, clock, reset,
                    rsp_valid_ff && rsp_ff.status == ST_OK, rsp_ff.cost < no_edge_ff)

endmodule

FILE: rtl/prim_minimum_spanning_tree_top.sv
`timescale 1ns / 1ps
// Prim spanning tree engine over a 16 by 16 adjacency matrix of 8-bit costs. A request is
// taken when start is high and busy is low. Results appear on rsp_data for one cycle with
// rsp_valid and cannot be stalled, so the receiver must take them as they come; the last
// result of a request is presented in the first cycle that busy is low again. All timing
// is set by a microcoded step counter driving one matrix memory with one write port and
// one registered read port. After reset busy stays high while the matrix is filled with
// the no-edge cost. Busy is also high while a clear, an edge write, a rejected request or
// a run is carried out. A run over n vertices (n at least 2) loads the start row, then per
// added vertex makes a search pass and, except after the last one, a relax pass. Configuration
// writes land at once and are meant for idle periods.
module prim_minimum_spanning_tree_top
   import pmst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pmst_req_type          req_data,
   output logic                  rsp_valid,
   output pmst_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   pmst_cmd_type   cmd;
   pmst_flags_type flags;

   // Step counter and control store
   pmst_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Matrix, tree state and result register
   pmst_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
